// File: design/dsf_pkg.sv
// Shared constants, types and helpers for the damped spring force pipeline.
package dsf_pkg;

    localparam int AXES        = 3;
    localparam int COORD_W     = 32;
    localparam int DIFF_W      = 33;
    localparam int SQ_W        = 66;
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 35;
    localparam int QUOT_W      = 31;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUOT_W;
    localparam int TAIL_STAGES = 7;
    localparam int NUM_STAGES  = 3 + SQRT_STAGES + DIV_STAGES + TAIL_STAGES;
    localparam int IN_W        = 12 * COORD_W;
    localparam int OUT_W       = 6 * COORD_W;
    localparam int F_W         = 56;

    localparam logic [31:0] DRAG_RESET = 32'd327680;

    typedef enum logic [1:0] {
        REG_STIFFNESS,
        REG_REST_LENGTH,
        REG_SPRING_DAMPING,
        REG_DRAG
    } reg_index_t;

    // per-item data that rides along the pipe
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] v1;
        logic [AXES-1:0][COORD_W-1:0] v2;
        logic [AXES-1:0][DIFF_W-1:0]  dv;
        logic [AXES-1:0]              dneg;
        logic [AXES-1:0][DIFF_W-1:0]  dmag;
    } carry_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [F_W-1:0] x);
        logic [COORD_W-1:0] r;
        if (x > $signed(F_W'(64'sd2147483647)))
            r = 32'h7FFF_FFFF;
        else if (x < -$signed(F_W'(64'sd2147483648)))
            r = 32'h8000_0000;
        else
            r = x[COORD_W-1:0];
        return r;
    endfunction

endpackage

// File: design/damped_spring_force.sv
// Damped Hooke spring force between two particles, fully pipelined.
//
//  channel | signals                          | payload (lowest bits first)
//  --------+----------------------------------+------------------------------------------
//  cfg     | cfg_we cfg_index cfg_wdata       | 0 stiffness, 1 rest_length, 2 damping, 3 drag
//  s (in)  | s_tvalid s_tready s_tdata[383:0] | p1 xyz, p2 xyz, v1 xyz, v2 xyz (32b each)
//  m (out) | m_tvalid m_tready m_tdata[191:0] | first force xyz, second force xyz
//
// One item per cycle while the output is not stalled. Stages: 3 front stages, 33 square
// root stages at one root bit each, 31 divider stages at one quotient bit each,
// 7 multiply/combine stages. All stages move together on one enable; a stalled
// output freezes the whole pipe, nothing is dropped or repeated.
// rst_n clears valid bits and loads register defaults (drag = 5.0).
module damped_spring_force (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  logic [dsf_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // first_force_x, _y, _z, second_force_x, _y, _z
    output logic [dsf_pkg::OUT_W-1:0]    m_tdata
);

    localparam int NS = dsf_pkg::NUM_STAGES;
    localparam int SQ = dsf_pkg::SQRT_STAGES;
    localparam int DV = dsf_pkg::DIV_STAGES;

    // ---------------- configuration registers ----------------
    logic [31:0] stiffness_reg;
    logic [30:0] rest_length_reg;
    logic [31:0] spring_damping_reg;
    logic [31:0] drag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg      <= '0;
            rest_length_reg    <= '0;
            spring_damping_reg <= '0;
            drag_reg           <= dsf_pkg::DRAG_RESET;
        end
        else if (cfg_we)
        begin
            case (dsf_pkg::reg_index_t'(cfg_index))
                dsf_pkg::REG_STIFFNESS:      stiffness_reg      <= cfg_wdata;
                dsf_pkg::REG_REST_LENGTH:    rest_length_reg    <= cfg_wdata[30:0];
                dsf_pkg::REG_SPRING_DAMPING: spring_damping_reg <= cfg_wdata;
                dsf_pkg::REG_DRAG:           drag_reg           <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic          adv;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;

    assign adv        = !valid_reg[NS-1] || m_tready;
    assign s_tready   = adv;
    assign m_tvalid   = valid_reg[NS-1];
    assign valid_next = {valid_reg[NS-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    // ---------------- stage 1: differences, magnitudes ----------------
    dsf_pkg::carry_t c1_next, c1_reg;

    always_comb
    begin
        logic [31:0] p1, p2, va, vb;
        logic [32:0] d, dvv;
        c1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            p1  = s_tdata[32*i +: 32];
            p2  = s_tdata[32*(3+i) +: 32];
            va  = s_tdata[32*(6+i) +: 32];
            vb  = s_tdata[32*(9+i) +: 32];
            d   = {p1[31], p1} - {p2[31], p2};
            dvv = {va[31], va} - {vb[31], vb};
            c1_next.v1[i]   = va;
            c1_next.v2[i]   = vb;
            c1_next.dv[i]   = dvv;
            c1_next.dneg[i] = d[32];
            c1_next.dmag[i] = d[32] ? (33'd0 - d) : d;
        end
    end

    // ---------------- stage 2: squares ----------------
    dsf_pkg::carry_t        c2_reg;
    logic [2:0][65:0]       sq_next, sq_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = 66'(c1_reg.dmag[i]) * 66'(c1_reg.dmag[i]);
    end

    // ---------------- stage 3: sum of squares ----------------
    dsf_pkg::carry_t c3_reg;
    logic [65:0]     ssum_next, ssum_reg;

    assign ssum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= c1_next;
            c2_reg   <= c1_reg;
            sq_reg   <= sq_next;
            c3_reg   <= c2_reg;
            ssum_reg <= ssum_next;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic [65:0]     rad_in   [SQ];
    logic [34:0]     rem_in   [SQ];
    logic [32:0]     root_in  [SQ];
    dsf_pkg::carry_t cs_in    [SQ];
    logic [65:0]     rad_next [SQ];
    logic [34:0]     rem_next [SQ];
    logic [32:0]     root_next[SQ];
    logic [65:0]     rad_reg  [SQ];
    logic [34:0]     rem_reg  [SQ];
    logic [32:0]     root_reg [SQ];
    dsf_pkg::carry_t cs_reg   [SQ];

    always_comb
    begin
        logic [36:0] tr_rem;
        logic [36:0] trial;
        rad_in[0]  = ssum_reg;
        rem_in[0]  = '0;
        root_in[0] = '0;
        cs_in[0]   = c3_reg;
        for (int j = 1; j < SQ; j++)
        begin
            rad_in[j]  = rad_reg[j-1];
            rem_in[j]  = rem_reg[j-1];
            root_in[j] = root_reg[j-1];
            cs_in[j]   = cs_reg[j-1];
        end
        for (int j = 0; j < SQ; j++)
        begin
            tr_rem      = {rem_in[j], rad_in[j][65:64]};
            trial       = {2'b00, root_in[j], 2'b01};
            rad_next[j] = {rad_in[j][63:0], 2'b00};
            if (tr_rem >= trial)
            begin
                rem_next[j]  = 35'(tr_rem - trial);
                root_next[j] = {root_in[j][31:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = tr_rem[34:0];
                root_next[j] = {root_in[j][31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < SQ; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                cs_reg[j]   <= cs_in[j];
            end
        end
    end

    // ---------------- divider: n = |d| * 2^30 / L, one bit per stage ----------------
    logic [32:0]       dlen_in  [DV];
    logic [2:0][32:0]  dr_in    [DV];
    logic [2:0][30:0]  dq_in    [DV];
    logic [2:0]        nbit_in  [DV];
    dsf_pkg::carry_t   dc_in    [DV];
    logic [2:0][32:0]  dr_next  [DV];
    logic [2:0][30:0]  dq_next  [DV];
    logic [32:0]       dlen_reg [DV];
    logic [2:0][32:0]  dr_reg   [DV];
    logic [2:0][30:0]  dq_reg   [DV];
    dsf_pkg::carry_t   dc_reg   [DV];

    always_comb
    begin
        logic [33:0] t;
        dlen_in[0] = root_reg[SQ-1];
        dc_in[0]   = cs_reg[SQ-1];
        dq_in[0]   = '0;
        for (int i = 0; i < 3; i++)
        begin
            // quotient stays below 2^31, so the top dividend bits start as remainder
            dr_in[0][i]   = {1'b0, cs_reg[SQ-1].dmag[i][32:1]};
            nbit_in[0][i] = cs_reg[SQ-1].dmag[i][0];
        end
        for (int j = 1; j < DV; j++)
        begin
            dlen_in[j] = dlen_reg[j-1];
            dc_in[j]   = dc_reg[j-1];
            dq_in[j]   = dq_reg[j-1];
            dr_in[j]   = dr_reg[j-1];
            nbit_in[j] = '0;
        end
        for (int j = 0; j < DV; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t = {dr_in[j][i], nbit_in[j][i]};
                if (t >= {1'b0, dlen_in[j]})
                begin
                    dr_next[j][i] = 33'(t - {1'b0, dlen_in[j]});
                    dq_next[j][i] = {dq_in[j][i][29:0], 1'b1};
                end
                else
                begin
                    dr_next[j][i] = t[32:0];
                    dq_next[j][i] = {dq_in[j][i][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < DV; j++)
            begin
                dlen_reg[j] <= dlen_in[j];
                dr_reg[j]   <= dr_next[j];
                dq_reg[j]   <= dq_next[j];
                dc_reg[j]   <= dc_in[j];
            end
        end
    end

    // ---------------- stage A: dv_i * n_i ----------------
    logic [2:0][30:0] nq;             // zero length gives zero unit vector
    logic [2:0][63:0] pa_next, pa_reg;
    logic [2:0]       pa_neg_next, pa_neg_reg;
    logic [32:0]      a_len_reg;
    logic [2:0][30:0] a_q_reg;
    dsf_pkg::carry_t  ca_reg;

    always_comb
    begin
        logic [32:0] dvm;
        for (int i = 0; i < 3; i++)
        begin
            nq[i]          = (dlen_reg[DV-1] != '0) ? dq_reg[DV-1][i] : '0;
            dvm            = dc_reg[DV-1].dv[i][32] ? (33'd0 - dc_reg[DV-1].dv[i])
                                                    : dc_reg[DV-1].dv[i];
            pa_next[i]     = 64'(dvm) * 64'(nq[i]);
            pa_neg_next[i] = dc_reg[DV-1].dv[i][32] ^ dc_reg[DV-1].dneg[i];
        end
    end

    // ---------------- stage B: relative speed along axis, stretch ----------------
    logic signed [34:0] rel_next, rel_reg;
    logic signed [33:0] diff_next, diff_reg;
    logic [2:0][30:0]   b_q_reg;
    dsf_pkg::carry_t    cb_reg;

    always_comb
    begin
        logic signed [34:0] term;
        rel_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            term     = $signed({1'b0, pa_reg[i][63:30]});
            rel_next = rel_next + (pa_neg_reg[i] ? -term : term);
        end
        diff_next = $signed({1'b0, a_len_reg}) - $signed({3'b000, rest_length_reg});
    end

    // ---------------- stage C: k*(L-L0), c*rel ----------------
    logic [49:0]      pk_next, pk_reg;
    logic [50:0]      pc_next, pc_reg;
    logic             pk_neg_reg, pc_neg_reg;
    logic [2:0][30:0] c_q_reg;
    dsf_pkg::carry_t  cc_reg;

    always_comb
    begin
        logic [33:0] dmg;
        logic [34:0] rmg;
        logic [65:0] pk_full;
        logic [66:0] pc_full;
        dmg     = diff_reg[33] ? 34'(-diff_reg) : 34'(diff_reg);
        rmg     = rel_reg[34] ? 35'(-rel_reg) : 35'(rel_reg);
        pk_full = 66'(dmg) * 66'(stiffness_reg);
        pc_full = 67'(rmg) * 67'(spring_damping_reg);
        pk_next = pk_full[65:16];
        pc_next = pc_full[66:16];
    end

    // ---------------- stage D: s and its magnitude ----------------
    logic [51:0]      smag_next, smag_reg;
    logic             sneg_next, sneg_reg;
    logic [2:0][30:0] d_q_reg;
    dsf_pkg::carry_t  cd_reg;

    always_comb
    begin
        logic signed [52:0] a, b, s;
        a         = $signed({3'b000, pk_reg});
        b         = $signed({2'b00, pc_reg});
        s         = (pk_neg_reg ? -a : a) + (pc_neg_reg ? -b : b);
        sneg_next = s[52];
        smag_next = s[52] ? 52'(-s) : 52'(s);
    end

    // ---------------- stage E: s*n partials, drag products ----------------
    logic [2:0][56:0] plo_next, plo_reg, phi_next, phi_reg;
    logic [2:0][47:0] g1_next, g1_reg, g2_next, g2_reg;
    logic             e_sneg_reg;
    dsf_pkg::carry_t  ce_reg;

    always_comb
    begin
        logic [31:0] m1, m2;
        logic [63:0] gp1, gp2;
        for (int i = 0; i < 3; i++)
        begin
            plo_next[i] = 57'(smag_reg[25:0])  * 57'(d_q_reg[i]);
            phi_next[i] = 57'(smag_reg[51:26]) * 57'(d_q_reg[i]);
            m1          = cd_reg.v1[i][31] ? (32'd0 - cd_reg.v1[i]) : cd_reg.v1[i];
            m2          = cd_reg.v2[i][31] ? (32'd0 - cd_reg.v2[i]) : cd_reg.v2[i];
            gp1         = 64'(m1) * 64'(drag_reg);
            gp2         = 64'(m2) * 64'(drag_reg);
            g1_next[i]  = gp1[63:16];
            g2_next[i]  = gp2[63:16];
        end
    end

    // ---------------- stage F: f_i = -(s*n_i >> 30) ----------------
    logic signed [2:0][53:0] f_next, f_reg;
    logic [2:0][47:0]        f_g1_reg, f_g2_reg;
    dsf_pkg::carry_t         cf_reg;

    always_comb
    begin
        logic [82:0] full;
        logic [52:0] fm;
        for (int i = 0; i < 3; i++)
        begin
            full = (83'(phi_reg[i]) << 26) + 83'(plo_reg[i]);
            fm   = full[82:30];
            // spring pulls against the axis: negative when s and n agree in sign
            f_next[i] = (e_sneg_reg ^ ce_reg.dneg[i]) ? $signed({1'b0, fm})
                                                       : -$signed({1'b0, fm});
        end
    end

    // ---------------- stage G: subtract drag, saturate ----------------
    logic [dsf_pkg::OUT_W-1:0] out_next, out_reg;

    always_comb
    begin
        logic signed [dsf_pkg::F_W-1:0] f, g1, g2;
        for (int i = 0; i < 3; i++)
        begin
            f  = dsf_pkg::F_W'($signed(f_reg[i]));
            g1 = $signed({8'h00, f_g1_reg[i]});
            g2 = $signed({8'h00, f_g2_reg[i]});
            g1 = cf_reg.v1[i][31] ? -g1 : g1;
            g2 = cf_reg.v2[i][31] ? -g2 : g2;
            out_next[32*i +: 32]     = dsf_pkg::sat32(f - g1);
            out_next[32*(3+i) +: 32] = dsf_pkg::sat32(-f - g2);
        end
    end

    assign m_tdata = out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg     <= pa_next;
            pa_neg_reg <= pa_neg_next;
            a_len_reg  <= dlen_reg[DV-1];
            a_q_reg    <= nq;
            ca_reg     <= dc_reg[DV-1];

            rel_reg    <= rel_next;
            diff_reg   <= diff_next;
            b_q_reg    <= a_q_reg;
            cb_reg     <= ca_reg;

            pk_reg     <= pk_next;
            pc_reg     <= pc_next;
            pk_neg_reg <= diff_reg[33];
            pc_neg_reg <= rel_reg[34];
            c_q_reg    <= b_q_reg;
            cc_reg     <= cb_reg;

            smag_reg   <= smag_next;
            sneg_reg   <= sneg_next;
            d_q_reg    <= c_q_reg;
            cd_reg     <= cc_reg;

            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            g1_reg     <= g1_next;
            g2_reg     <= g2_next;
            e_sneg_reg <= sneg_reg;
            ce_reg     <= cd_reg;

            f_reg      <= f_next;
            f_g1_reg   <= g1_reg;
            f_g2_reg   <= g2_reg;
            cf_reg     <= ce_reg;

            out_reg    <= out_next;
        end
    end

endmodule

// File: sim/damped_spring_force_test.sv
// Self-checking stream testbench for the damped spring force pipeline.
module damped_spring_force_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PIPE_DEPTH  = 74;      // number of pipeline stages in the block
    localparam int  CYCLE_LIMIT = 600000;  // far above the slowest legal run
    localparam int  HOLD_CYCLES = 400;     // long receiver hold-off
    localparam longint MAG_CAP  = 64'h4000_0000_0000_0000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    dsf_pkg::reg_index_t          cfg_sel;
    logic [31:0]                  cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    logic [dsf_pkg::IN_W-1:0]     s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    // first_force_x, _y, _z, second_force_x, _y, _z
    logic [dsf_pkg::OUT_W-1:0]    m_tdata;

    damped_spring_force dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_sel),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mirror of the register file, updated as each write lands.
    logic [31:0] k_gain;
    logic [30:0] rest_len;
    logic [31:0] axial_damp;
    logic [31:0] drag_gain;

    logic [dsf_pkg::OUT_W-1:0] force_queue[$];   // predicted force items, oldest first
    int               fail_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;
    event             hold_go;           // starts the long receiver hold-off
    bit               hold_active;

    typedef struct {
        int  fld[12];
        int  res[6];
        bit  typed;   // res holds the expected forces read off by hand
    } stim_row_t;

    stim_row_t dir_rows[$];

    string force_names[6] = '{"first_force_x", "first_force_y", "first_force_z",
                              "second_force_x", "second_force_y", "second_force_z"};

    // ---------------------------------------------------------------- clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long hold-off, counted here in clock cycles
    always begin
        @(hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    // a*b / 2^sh, truncated toward zero, magnitude clamped at MAG_CAP
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic [127:0] ma, mb, prod;
        longint       m;
        ma   = (a < 0) ? 128'(-a) : 128'(a);
        mb   = (b < 0) ? 128'(-b) : 128'(b);
        prod = (ma * mb) >> sh;
        m    = (prod > 128'(MAG_CAP)) ? MAG_CAP : longint'(prod[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [dsf_pkg::OUT_W-1:0] spring_forces(
        logic [dsf_pkg::IN_W-1:0] item);
        longint                    coord[12];
        longint                    dpos[3], dvel[3], unit_n[3], fs[3];
        logic [127:0]              sq_sum, cand_sq;
        longint unsigned           root, cand, mag, q;
        longint                    closing, scalar, g1, g2;
        logic [dsf_pkg::OUT_W-1:0] res;
        for (int i = 0; i < 12; i++)
            coord[i] = longint'($signed(item[32*i +: 32]));
        sq_sum = '0;
        for (int i = 0; i < 3; i++) begin
            dpos[i] = coord[i] - coord[3+i];
            dvel[i] = coord[6+i] - coord[9+i];
            mag     = (dpos[i] < 0) ? -dpos[i] : dpos[i];
            sq_sum  = sq_sum + 128'(mag) * 128'(mag);
            unit_n[i] = 0;
            fs[i]     = 0;
        end
        // bitwise integer square root, 34 result bits
        root = 0;
        for (int b = 33; b >= 0; b--) begin
            cand    = root | (64'd1 << b);
            cand_sq = 128'(cand) * 128'(cand);
            if (cand_sq <= sq_sum)
                root = cand;
        end
        // coincident particles leave only the drag terms
        if (root > 0) begin
            closing = 0;
            for (int i = 0; i < 3; i++) begin
                mag       = (dpos[i] < 0) ? -dpos[i] : dpos[i];
                q         = (mag << 30) / root;
                unit_n[i] = (dpos[i] < 0) ? -longint'(q) : longint'(q);
                closing  += scaled_product(dvel[i], unit_n[i], 30);
            end
            scalar = scaled_product(longint'(root) - longint'(rest_len),
                                    longint'(k_gain), 16)
                   + scaled_product(closing, longint'(axial_damp), 16);
            for (int i = 0; i < 3; i++)
                fs[i] = -scaled_product(scalar, unit_n[i], 30);
        end
        for (int i = 0; i < 3; i++) begin
            g1 = scaled_product(coord[6+i], longint'(drag_gain), 16);
            g2 = scaled_product(coord[9+i], longint'(drag_gain), 16);
            res[32*i +: 32]     = clamp32(fs[i] - g1);
            res[32*(3+i) +: 32] = clamp32(-fs[i] - g2);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- config
    // Holds cfg_we high across back-to-back writes; caller drops it.
    task automatic write_reg(dsf_pkg::reg_index_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_sel   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            dsf_pkg::REG_STIFFNESS:      k_gain     = val;
            dsf_pkg::REG_REST_LENGTH:    rest_len   = val[30:0];
            dsf_pkg::REG_SPRING_DAMPING: axial_damp = val;
            dsf_pkg::REG_DRAG:           drag_gain  = val;
            default: ;
        endcase
    endtask

    task automatic load_spring(logic [31:0] k, logic [31:0] l0,
                               logic [31:0] c, logic [31:0] dg);
        write_reg(dsf_pkg::REG_STIFFNESS, k);
        write_reg(dsf_pkg::REG_REST_LENGTH, l0);
        write_reg(dsf_pkg::REG_SPRING_DAMPING, c);
        write_reg(dsf_pkg::REG_DRAG, dg);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Block idle: all forces back, then let the pipe run empty.
    task automatic drain_pipe();
        while (force_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- sender
    // typed_res: when typed is set, use hand-read forces instead of the predictor
    task automatic push_pair(logic [dsf_pkg::IN_W-1:0] item, bit typed,
                             logic [dsf_pkg::OUT_W-1:0] typed_res);
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge clk);
        while (!s_tready);
        force_queue.push_back(typed ? typed_res : spring_forces(item));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {12{$urandom}};
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic int rand_coord();
        case ($urandom_range(9))
            0, 1:    return $urandom;                            // full range
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return int'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [dsf_pkg::IN_W-1:0] random_pair();
        logic [dsf_pkg::IN_W-1:0] item;
        int                       shape;
        shape = $urandom_range(9);
        for (int i = 0; i < 12; i++)
            item[32*i +: 32] = rand_coord();
        if (shape == 0)             // coincident particles
            item[96 +: 96] = item[0 +: 96];
        else if (shape == 1) begin  // one LSB apart on one axis
            item[96 +: 96] = item[0 +: 96];
            item[96 + 32*$urandom_range(2) +: 32] += ($urandom_range(1) ? 1 : -1);
        end
        return item;
    endfunction

    // ---------------------------------------------------------------- receiver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (force_queue.size() == 0) begin
                    $error("force item with nothing expected: %h", m_tdata);
                    fail_count++;
                end
                else begin
                    logic [dsf_pkg::OUT_W-1:0] want;
                    want = force_queue.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                            $error("%s expected %0d got %0d", force_names[i],
                                   $signed(want[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
                            fail_count++;
                        end
                end
            end
            if (hold_active)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [dsf_pkg::IN_W-1:0]  item;
        logic [dsf_pkg::OUT_W-1:0] res;
        logic [31:0]               cfg_set[6][4];
        int                        idle_mode[4][2];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_sel        = dsf_pkg::REG_STIFFNESS;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        k_gain         = '0;
        rest_len       = '0;
        axial_damp     = '0;
        drag_gain      = dsf_pkg::DRAG_RESET;

        // Directed rows: reset defaults first (k = L0 = c = 0, drag 5.0)
        dir_rows.push_back('{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, '{0,0,0,0,0,0}, 1});
        // coincident, unit velocities: only drag remains
        dir_rows.push_back('{'{7,7,7, 7,7,7, 65536,0,0, 0,-65536,0},
                             '{-327680,0,0, 0,327680,0}, 1});
        // extreme velocities saturate the drag term
        dir_rows.push_back('{'{0,0,0, 0,0,0, 32'h8000_0000,32'h7FFF_FFFF,0,
                               0,0,32'h8000_0000},
                             '{32'h7FFF_FFFF,32'h8000_0000,0,
                               0,0,32'h7FFF_FFFF}, 1});
        for (int i = 0; i < dir_rows.size(); i++) begin
            for (int f = 0; f < 12; f++)
                item[32*f +: 32] = dir_rows[i].fld[f];
            for (int f = 0; f < 6; f++)
                res[32*f +: 32] = dir_rows[i].res[f];
            dir_rows[i].typed = dir_rows[i].typed;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-default rows, hand-checked
        foreach (dir_rows[i]) begin
            for (int f = 0; f < 12; f++)
                item[32*f +: 32] = dir_rows[i].fld[f];
            for (int f = 0; f < 6; f++)
                res[32*f +: 32] = dir_rows[i].res[f];
            push_pair(item, 1'b1, res);
        end
        s_tvalid <= 1'b0;
        drain_pipe();

        // live spring: k 2.0, L0 1.0 (bit 31 written to show it is dropped), c 0.5,
        // drag 0.25
        load_spring(32'h0002_0000, 32'h8001_0000, 32'h0000_8000, 32'h0000_4000);
        dir_rows.delete();
        dir_rows.push_back('{'{65536,0,0, 0,0,0, 0,0,0, 0,0,0}, '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{0,3*65536,0, 0,0,0, 0,65536,0, 0,0,0}, '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{0,0,-5*65536, 0,0,0, 0,0,0, 0,0,-65536},
                             '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{1,0,0, 0,0,0, 100,0,0, -100,0,0}, '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{0,0,0, 0,-1,0, 0,0,0, 0,0,0}, '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF,
                               32'h8000_0000,32'h8000_0000,32'h8000_0000,
                               32'h7FFF_FFFF,32'h8000_0000,32'h7FFF_FFFF,
                               32'h8000_0000,32'h7FFF_FFFF,32'h8000_0000},
                             '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{32'h8000_0000,0,0, 32'h7FFF_FFFF,0,0, 0,0,0, 0,0,0},
                             '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{3*65536,4*65536,12*65536, 0,0,0,
                               65536,-65536,2*65536, -3*65536,0,65536},
                             '{0,0,0,0,0,0}, 0});
        dir_rows.push_back('{'{-1,-1,-1, 0,0,0, -1,-1,-1, 1,1,1}, '{0,0,0,0,0,0}, 0});
        foreach (dir_rows[i]) begin
            for (int f = 0; f < 12; f++)
                item[32*f +: 32] = dir_rows[i].fld[f];
            push_pair(item, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        drain_pipe();

        // Random phases: spring settings (extremes included) x idling modes
        cfg_set = '{'{32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 32'h0005_0000},
                    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
                    '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    '{32'h0010_0000, 32'h0003_0000, 32'h0000_0100, 32'h0000_0001},
                    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_8000},
                    '{32'h0000_8000, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000}};
        idle_mode = '{'{0, 0}, '{73, 0}, '{0, 73}, '{32, 32}};
        for (int ph = 0; ph < 6; ph++) begin
            load_spring(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2], cfg_set[ph][3]);
            send_idle_pct  = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            // back-pressure burst: receiver holds off while items keep coming
            if (ph == 0)
                -> hold_go;
            for (int n = 0; n < 115; n++) begin
                push_pair(random_pair(), 1'b0, '0);
                // once, stop sending until the pipe has given everything back
                if (ph == 3 && n == 60) begin
                    s_tvalid <= 1'b0;
                    while (force_queue.size() != 0)
                        @(posedge clk);
                end
            end
            s_tvalid <= 1'b0;
            drain_pipe();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
design/dsf_pkg.sv
design/damped_spring_force.sv
sim/damped_spring_force_test.sv
